// ===== sv/segment_bucket_merge_table_assert.svh =====
// assertion macros for the segment bucket merge table
`ifndef SEGMENT_BUCKET_MERGE_TABLE_ASSERT_SVH
`define SEGMENT_BUCKET_MERGE_TABLE_ASSERT_SVH

// invariant checked on every edge out of reset
`define SBMT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication checked out of reset
`define SBMT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/sbmt_pkg.sv =====
// shared constants, codes and types for the segment bucket merge table
`timescale 1ns / 1ps
package sbmt_pkg;
   localparam int NUM_BUCKETS      = 256;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int COORD_BITS       = 10;

   localparam int BKT_W  = $clog2(NUM_BUCKETS);
   localparam int SLOT_W = $clog2(SLOTS_PER_BUCKET);
   localparam int CNT_W  = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int ADDR_W = BKT_W + SLOT_W;
   localparam int OCC_W  = $clog2(NUM_BUCKETS + 1);
   localparam int SIDX_W = BKT_W + 2;
   localparam int WIN_W  = 6;
   localparam int ACT_W  = 2;
   localparam int OUTC_W = 3;
   localparam int SEG_W  = 4 * COORD_BITS;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

   localparam logic [ACT_W-1:0] ACT_PLAIN = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SNAP  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MERGE = 2'd2;
   // unused code, handled as a plain insert
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   localparam logic [OUTC_W-1:0] OUTC_NEW      = 3'd0;
   localparam logic [OUTC_W-1:0] OUTC_APPENDED = 3'd1;
   localparam logic [OUTC_W-1:0] OUTC_REJECTED = 3'd2;
   localparam logic [OUTC_W-1:0] OUTC_REPLACED = 3'd3;
   localparam logic [OUTC_W-1:0] OUTC_MERGED   = 3'd4;
   localparam logic [OUTC_W-1:0] OUTC_DROPPED  = 3'd5;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      coord_type        start_x;
      coord_type        start_y;
      coord_type        end_x;
      coord_type        end_y;
      logic [BKT_W-1:0] bucket;
   } sbmt_item_type;

   typedef struct packed {
      coord_type         res_start_x;
      coord_type         res_start_y;
      coord_type         res_end_x;
      coord_type         res_end_y;
      logic [BKT_W-1:0]  target_bucket;
      logic [OUTC_W-1:0] outcome;
      logic [OCC_W-1:0]  occupied_buckets;
   } sbmt_result_type;

   typedef struct packed {
      logic load;
      logic srch_rd;
      logic dec_idx;
      logic take_nb;
      logic cnt_rd;
      logic cnt_latch;
      logic scan_rd;
      logic scan_chk;
      logic flag_out;
      logic append;
      logic merge_rd;
      logic merge_wr;
      logic emit;
   } sbmt_cmd_type;

   typedef struct packed {
      logic search_act;
      logic merge_act;
      logic srch_cont;
      logic srch_found;
      logic cnt_zero;
      logic scan_last;
      logic scan_hit;
      logic rsp_free;
   } sbmt_sts_type;
endpackage

// ===== sv/sbmt_if.sv =====
// handshake channels: request, response and register write
`timescale 1ns / 1ps
interface sbmt_req_if import sbmt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   coord_type        start_x;
   coord_type        start_y;
   coord_type        end_x;
   coord_type        end_y;
   logic [BKT_W-1:0] bucket;
   modport source (output valid, action, start_x, start_y, end_x, end_y, bucket,
                   input ready);
   modport sink   (input valid, action, start_x, start_y, end_x, end_y, bucket,
                   output ready);
endinterface

interface sbmt_rsp_if import sbmt_pkg::*; ();
   logic              valid;
   logic              ready;
   coord_type         res_start_x;
   coord_type         res_start_y;
   coord_type         res_end_x;
   coord_type         res_end_y;
   logic [BKT_W-1:0]  target_bucket;
   logic [OUTC_W-1:0] outcome;
   logic [OCC_W-1:0]  occupied_buckets;
   modport source (output valid, res_start_x, res_start_y, res_end_x, res_end_y,
                   target_bucket, outcome, occupied_buckets, input ready);
   modport sink   (input valid, res_start_x, res_start_y, res_end_x, res_end_y,
                   target_bucket, outcome, occupied_buckets, output ready);
endinterface

interface sbmt_csr_if import sbmt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/sbmt_ctrl.sv =====
// sequencing state machine for search, slot scan, append and merge
`timescale 1ns / 1ps
module sbmt_ctrl import sbmt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sbmt_sts_type sts,
   output sbmt_cmd_type cmd
);
   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_SRCH_RD  = 11'b000_0000_0010,
      ST_SRCH_CHK = 11'b000_0000_0100,
      ST_CNT_RD   = 11'b000_0000_1000,
      ST_CNT_CHK  = 11'b000_0001_0000,
      ST_SCAN_RD  = 11'b000_0010_0000,
      ST_SCAN_CHK = 11'b000_0100_0000,
      ST_APPEND   = 11'b000_1000_0000,
      ST_MERGE_RD = 11'b001_0000_0000,
      ST_MERGE_WR = 11'b010_0000_0000,
      ST_FINISH   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      app_only_ff, app_only_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      app_only_in = app_only_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               app_only_in = 1'b0;
               state_in    = sts.search_act ? ST_SRCH_RD : ST_CNT_RD;
            end
         end
         ST_SRCH_RD: begin
            cmd.srch_rd = 1'b1;
            state_in    = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            if (sts.srch_cont) begin
               cmd.dec_idx = 1'b1;
               state_in    = ST_SRCH_RD;
            end else if (sts.srch_found) begin
               cmd.take_nb = 1'b1;
               state_in    = sts.merge_act ? ST_MERGE_RD : ST_CNT_RD;
            end else begin
               // no neighbour: append at own bucket without checks
               app_only_in = 1'b1;
               state_in    = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_CNT_CHK;
         end
         ST_CNT_CHK: begin
            cmd.cnt_latch = 1'b1;
            state_in      = (app_only_ff || sts.cnt_zero) ? ST_APPEND : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            if (sts.scan_last) begin
               if (sts.scan_hit) begin
                  cmd.flag_out = 1'b1;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_APPEND;
               end
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_MERGE_RD: begin
            cmd.merge_rd = 1'b1;
            state_in     = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            cmd.merge_wr = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         app_only_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         app_only_ff <= app_only_in;
      end
   end
endmodule

// ===== sv/sbmt_dp.sv =====
// datapath: segment store, slot counts, neighbour search and compare logic
`timescale 1ns / 1ps
`include "segment_bucket_merge_table_assert.svh"
module sbmt_dp import sbmt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sbmt_item_type    item,
   input  logic             csr_we,
   input  logic [WIN_W-1:0] csr_data,
   input  sbmt_cmd_type     cmd,
   output sbmt_sts_type     sts,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output sbmt_result_type  rsp_data
);
   logic [SEG_W-1:0]  seg_mem [NUM_BUCKETS*SLOTS_PER_BUCKET];
   logic [CNT_W-1:0]  cnt_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] cnt_vld_ff;

   logic [WIN_W-1:0]  window_ff;
   logic [OCC_W-1:0]  occ_ff;
   coord_type         s_ff [4];
   logic [ACT_W-1:0]  act_ff;
   logic [BKT_W-1:0]  tgt_ff, idx_ff;
   logic signed [SIDX_W-1:0] lo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SLOT_W-1:0] j_ff;
   logic              rej_ff, rep_ff;
   logic [OUTC_W-1:0] outc_ff;
   logic [CNT_W-1:0]  cnt_q_ff;
   logic              vld_q_ff;
   logic [SEG_W-1:0]  seg_q_ff;
   logic              rsp_valid_ff;
   sbmt_result_type   rsp_ff;

   logic [BKT_W-1:0]  cnt_raddr;
   logic [ADDR_W-1:0] seg_raddr, seg_waddr;
   logic [SEG_W-1:0]  seg_wdata;
   logic              seg_we;
   logic [CNT_W-1:0]  cnt_rd;
   coord_type         e [4];
   coord_type         mrg [4];
   logic [COORD_BITS-1:0] dx, dy;
   logic              vert;
   logic              eq_hit, rej_hit, rep_hit;
   logic [WIN_W-2:0]  half;
   logic [BKT_W:0]    top;
   logic signed [SIDX_W-1:0] sidx;
   coord_type         tgt_coord;

   assign half   = window_ff[WIN_W-1:1];
   assign top    = {1'b0, item.bucket} + (BKT_W+1)'(half);
   assign cnt_rd = vld_q_ff ? cnt_q_ff : '0;
   assign sidx   = $signed({2'b00, idx_ff});

   assign dx   = (s_ff[0] >= s_ff[2]) ? s_ff[0] - s_ff[2] : s_ff[2] - s_ff[0];
   assign dy   = (s_ff[1] >= s_ff[3]) ? s_ff[1] - s_ff[3] : s_ff[3] - s_ff[1];
   assign vert = dx < dy;
   assign tgt_coord = COORD_BITS'(idx_ff);

   assign e[0] = seg_q_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign e[1] = seg_q_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign e[2] = seg_q_ff[2*COORD_BITS-1:COORD_BITS];
   assign e[3] = seg_q_ff[COORD_BITS-1:0];

   assign eq_hit  = (s_ff[0] == e[0]) && (s_ff[1] == e[1]) &&
                    (s_ff[2] == e[2]) && (s_ff[3] == e[3]);
   assign rej_hit = eq_hit || (s_ff[0] >= e[0] && s_ff[2] <= e[2]) ||
                    (s_ff[1] >= e[1] && s_ff[3] <= e[3]);
   assign rep_hit = !rej_hit && ((s_ff[0] <= e[0] && s_ff[2] >= e[2]) ||
                    (s_ff[1] <= e[1] && s_ff[3] >= e[3]));

   // merge clips entry 0 along the long axis
   always_comb begin
      mrg = e;
      if (vert) begin
         if (s_ff[1] > e[1]) mrg[1] = s_ff[1];
         if (s_ff[3] < e[3]) mrg[3] = s_ff[3];
      end else begin
         if (s_ff[0] > e[0]) mrg[0] = s_ff[0];
         if (s_ff[2] < e[2]) mrg[2] = s_ff[2];
      end
   end

   assign cnt_raddr = cmd.srch_rd ? idx_ff : tgt_ff;
   assign seg_raddr = cmd.scan_rd ? {tgt_ff, j_ff} : {tgt_ff, SLOT_W'(0)};

   always_comb begin
      seg_we    = 1'b0;
      seg_waddr = {tgt_ff, j_ff};
      seg_wdata = {s_ff[0], s_ff[1], s_ff[2], s_ff[3]};
      if (cmd.scan_chk && rep_hit) begin
         seg_we = 1'b1;
      end else if (cmd.append && (cnt_ff < CNT_W'(SLOTS_PER_BUCKET))) begin
         seg_we    = 1'b1;
         seg_waddr = {tgt_ff, cnt_ff[SLOT_W-1:0]};
      end else if (cmd.merge_wr) begin
         seg_we    = 1'b1;
         seg_waddr = {tgt_ff, SLOT_W'(0)};
         seg_wdata = {mrg[0], mrg[1], mrg[2], mrg[3]};
      end
   end

   always_comb begin
      sts.search_act = (item.action == ACT_SNAP) || (item.action == ACT_MERGE);
      sts.merge_act  = (act_ff == ACT_MERGE);
      sts.srch_cont  = (sidx >= lo_ff) && (idx_ff != '0) && (cnt_rd == '0);
      sts.srch_found = (sidx > lo_ff) && (cnt_rd != '0);
      sts.cnt_zero   = (cnt_rd == '0);
      sts.scan_last  = ({1'b0, j_ff} + CNT_W'(1)) == cnt_ff;
      sts.scan_hit   = rej_ff || rep_ff || rej_hit || rep_hit;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      seg_q_ff <= seg_mem[seg_raddr];
      if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
      cnt_q_ff <= cnt_mem[cnt_raddr];
      if (cmd.append && (cnt_ff < CNT_W'(SLOTS_PER_BUCKET))) begin
         cnt_mem[tgt_ff] <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         occ_ff       <= '0;
         cnt_vld_ff   <= '0;
         vld_q_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_q_ff <= cnt_vld_ff[cnt_raddr];
         if (csr_we) window_ff <= csr_data;
         if (cmd.append && (cnt_ff < CNT_W'(SLOTS_PER_BUCKET))) begin
            cnt_vld_ff[tgt_ff] <= 1'b1;
            if (cnt_ff == '0) occ_ff <= occ_ff + OCC_W'(1);
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= item.action;
         s_ff[0] <= item.start_x;
         s_ff[1] <= item.start_y;
         s_ff[2] <= item.end_x;
         s_ff[3] <= item.end_y;
         tgt_ff  <= item.bucket;
         // search starts at bucket+half, clamped to the top bucket
         idx_ff  <= top[BKT_W] ? BKT_W'(NUM_BUCKETS - 1) : top[BKT_W-1:0];
         lo_ff   <= $signed({2'b00, item.bucket}) - $signed(SIDX_W'(half));
         rej_ff  <= 1'b0;
         rep_ff  <= 1'b0;
      end
      if (cmd.dec_idx) idx_ff <= idx_ff - BKT_W'(1);
      if (cmd.take_nb) begin
         tgt_ff <= idx_ff;
         if (act_ff == ACT_SNAP) begin
            if (vert) begin
               s_ff[0] <= tgt_coord;
               s_ff[2] <= tgt_coord;
            end else begin
               s_ff[1] <= tgt_coord;
               s_ff[3] <= tgt_coord;
            end
         end
      end
      if (cmd.cnt_latch) begin
         cnt_ff <= cnt_rd;
         j_ff   <= '0;
      end
      if (cmd.scan_chk) begin
         j_ff <= j_ff + SLOT_W'(1);
         if (rej_hit) rej_ff <= 1'b1;
         if (rep_hit) rep_ff <= 1'b1;
      end
      if (cmd.flag_out) begin
         outc_ff <= (rep_ff || rep_hit) ? OUTC_REPLACED : OUTC_REJECTED;
      end
      if (cmd.append) begin
         if (cnt_ff >= CNT_W'(SLOTS_PER_BUCKET)) outc_ff <= OUTC_DROPPED;
         else if (cnt_ff == '0) outc_ff <= OUTC_NEW;
         else outc_ff <= OUTC_APPENDED;
      end
      if (cmd.merge_wr) begin
         s_ff    <= mrg;
         outc_ff <= OUTC_MERGED;
      end
      if (cmd.emit) begin
         rsp_ff.res_start_x      <= s_ff[0];
         rsp_ff.res_start_y      <= s_ff[1];
         rsp_ff.res_end_x        <= s_ff[2];
         rsp_ff.res_end_y        <= s_ff[3];
         rsp_ff.target_bucket    <= tgt_ff;
         rsp_ff.outcome          <= outc_ff;
         rsp_ff.occupied_buckets <= occ_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SBMT_ASSERT(a_occ_bound, clock, reset, occ_ff <= OCC_W'(NUM_BUCKETS), "occupied count above bucket total")
   `SBMT_ASSERT(a_occ_step, clock, reset, (occ_ff == $past(occ_ff)) || (occ_ff == $past(occ_ff) + OCC_W'(1)), "occupied count moved by more than one")
   `SBMT_ASSERT_IMP(a_scan_cnt, clock, reset, cmd.scan_chk, (cnt_ff != '0) && (cnt_ff <= CNT_W'(SLOTS_PER_BUCKET)), "slot scan with bad count")
endmodule

// ===== sv/segment_bucket_merge_table.sv =====
// top level: segment bucket merge table
// the neighbour search steps bucket by bucket, reading the slot count memory
// the slot scan reads each stored slot through the segment memory read port
// one item in flight; the next request is taken once the result sits in the output register
// reset (synchronous, active high) empties all buckets at once and sets window_width to 4
`timescale 1ns / 1ps
module segment_bucket_merge_table import sbmt_pkg::*; (
   input logic        clock,
   input logic        reset,
   sbmt_req_if.sink   req,
   sbmt_rsp_if.source rsp,
   sbmt_csr_if.sink   csr
);
   sbmt_cmd_type    cmd;
   sbmt_sts_type    sts;
   sbmt_item_type   item;
   sbmt_result_type res;
   logic            req_ready;

   assign item.action  = req.action;
   assign item.start_x = req.start_x;
   assign item.start_y = req.start_y;
   assign item.end_x   = req.end_x;
   assign item.end_y   = req.end_y;
   assign item.bucket  = req.bucket;
   assign req.ready    = req_ready;
   assign csr.ready    = 1'b1;

   sbmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sbmt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .csr_we    (csr.valid),
      .csr_data  (csr.data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_data  (res)
   );

   assign rsp.res_start_x      = res.res_start_x;
   assign rsp.res_start_y      = res.res_start_y;
   assign rsp.res_end_x        = res.res_end_x;
   assign rsp.res_end_y        = res.res_end_y;
   assign rsp.target_bucket    = res.target_bucket;
   assign rsp.outcome          = res.outcome;
   assign rsp.occupied_buckets = res.occupied_buckets;
endmodule

// ===== verif/tb_segment_bucket_merge_table.sv =====
// testbench for the segment bucket merge table: predicts each result and checks it
`timescale 1ns / 1ps
module tb_segment_bucket_merge_table import sbmt_pkg::*; ();

   typedef struct {
      logic [ACT_W-1:0] action;
      coord_type        sx, sy, ex, ey;
      logic [BKT_W-1:0] bucket;
   } seg_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbmt_req_if req ();
   sbmt_rsp_if rsp ();
   sbmt_csr_if csr ();

   segment_bucket_merge_table dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   coord_type        seg_mem [NUM_BUCKETS][SLOTS_PER_BUCKET][4];
   int unsigned      fill [NUM_BUCKETS];
   int unsigned      occupied_now;
   logic [WIN_W-1:0] window_now;

   sbmt_result_type  expected_results [$];
   int               mismatch_count;
   int               result_count;
   int               item_count;
   int               outcome_seen [6];
   longint           cycle_count;
   bit               hold_off;
   bit               no_gaps;
   int               rsp_wait;

   function automatic bit seg_vertical(coord_type s [4]);
      int dx, dy;
      dx = int'(s[0]) - int'(s[2]);
      dy = int'(s[1]) - int'(s[3]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx < dy;
   endfunction

   function automatic logic [OUTC_W-1:0] append_segment(int b, coord_type s [4]);
      int c;
      c = fill[b];
      if (c >= SLOTS_PER_BUCKET) return OUTC_DROPPED;
      for (int k = 0; k < 4; k++) seg_mem[b][c][k] = s[k];
      fill[b] = c + 1;
      if (c == 0) begin
         occupied_now++;
         return OUTC_NEW;
      end
      return OUTC_APPENDED;
   endfunction

   function automatic logic [OUTC_W-1:0] insert_checked(int b, coord_type s [4]);
      bit rej, rep;
      rej = 0;
      rep = 0;
      for (int j = 0; j < fill[b]; j++) begin
         if (s[0] == seg_mem[b][j][0] && s[1] == seg_mem[b][j][1] &&
             s[2] == seg_mem[b][j][2] && s[3] == seg_mem[b][j][3]) begin
            rej = 1;
         end else if ((s[0] >= seg_mem[b][j][0] && s[2] <= seg_mem[b][j][2]) ||
                      (s[1] >= seg_mem[b][j][1] && s[3] <= seg_mem[b][j][3])) begin
            rej = 1;
         end else if ((s[0] <= seg_mem[b][j][0] && s[2] >= seg_mem[b][j][2]) ||
                      (s[1] <= seg_mem[b][j][1] && s[3] >= seg_mem[b][j][3])) begin
            for (int k = 0; k < 4; k++) seg_mem[b][j][k] = s[k];
            rep = 1;
         end
      end
      if (rep) return OUTC_REPLACED;
      if (rej) return OUTC_REJECTED;
      return append_segment(b, s);
   endfunction

   function automatic int nearest_occupied(int pos);
      int half, i;
      half = int'(window_now) / 2;
      i = pos + half;
      if (i > NUM_BUCKETS - 1) i = NUM_BUCKETS - 1;
      while (i >= pos - half && i > 0 && fill[i] == 0) i--;
      if (i < 0 || i <= pos - half || fill[i] == 0) return -1;
      return i;
   endfunction

   function automatic sbmt_result_type predict_table_update(seg_item_type it);
      sbmt_result_type r;
      coord_type s [4];
      int pos, nb, a;
      logic [OUTC_W-1:0] oc;
      s[0] = it.sx; s[1] = it.sy; s[2] = it.ex; s[3] = it.ey;
      pos = it.bucket;
      r.target_bucket = it.bucket;
      if (it.action == ACT_SNAP || it.action == ACT_MERGE) begin
         nb = nearest_occupied(pos);
         if (nb < 0) begin
            oc = append_segment(pos, s);
         end else begin
            r.target_bucket = nb[BKT_W-1:0];
            if (it.action == ACT_SNAP) begin
               if (seg_vertical(s)) begin
                  s[0] = coord_type'(nb);
                  s[2] = coord_type'(nb);
               end else begin
                  s[1] = coord_type'(nb);
                  s[3] = coord_type'(nb);
               end
               oc = insert_checked(nb, s);
            end else begin
               a = seg_vertical(s) ? 1 : 0;
               if (s[a] > seg_mem[nb][0][a]) seg_mem[nb][0][a] = s[a];
               if (s[a+2] < seg_mem[nb][0][a+2]) seg_mem[nb][0][a+2] = s[a+2];
               for (int k = 0; k < 4; k++) s[k] = seg_mem[nb][0][k];
               oc = OUTC_MERGED;
            end
         end
      end else begin
         oc = insert_checked(pos, s);
      end
      r.res_start_x = s[0];
      r.res_start_y = s[1];
      r.res_end_x = s[2];
      r.res_end_y = s[3];
      r.outcome = oc;
      r.occupied_buckets = OCC_W'(occupied_now);
      return r;
   endfunction

   // valid stays up after a transfer when the next item follows at once
   task automatic send_segment(seg_item_type it);
      int gap;
      gap = no_gaps ? 0 : int'($urandom_range(0, 18));
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.action  <= it.action;
      req.start_x <= it.sx;
      req.start_y <= it.sy;
      req.end_x   <= it.ex;
      req.end_y   <= it.ey;
      req.bucket  <= it.bucket;
      do @(posedge clock); while (!req.ready);
      expected_results.push_back(predict_table_update(it));
      item_count++;
   endtask

   task automatic send_fields(logic [ACT_W-1:0] act, int sx, int sy, int ex, int ey, int b);
      seg_item_type it;
      it.action = act;
      it.sx = coord_type'(sx); it.sy = coord_type'(sy);
      it.ex = coord_type'(ex); it.ey = coord_type'(ey);
      it.bucket = BKT_W'(b);
      send_segment(it);
   endtask

   task automatic drain_results;
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_W-1:0] w);
      drain_results();
      csr.valid <= 1'b1;
      csr.data  <= w;
      do @(posedge clock); while (!csr.ready);
      window_now = w;
      csr.valid <= 1'b0;
   endtask

   // result side: a drawn wait before each transfer, or a long hold-off when requested
   always @(posedge clock) begin
      int w;
      if (reset || hold_off) begin
         rsp.ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp.valid && rsp.ready) begin
         w = no_gaps ? 0 : int'($urandom_range(0, 18));
         rsp_wait  <= w;
         rsp.ready <= (w == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp.ready <= (rsp_wait == 1);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sbmt_result_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.res_start_x = rsp.res_start_x;
         got.res_start_y = rsp.res_start_y;
         got.res_end_x = rsp.res_end_x;
         got.res_end_y = rsp.res_end_y;
         got.target_bucket = rsp.target_bucket;
         got.outcome = rsp.outcome;
         got.occupied_buckets = rsp.occupied_buckets;
         result_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transfer %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got.outcome <= OUTC_DROPPED) outcome_seen[got.outcome]++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at result %0d: expected %p actual %p",
                           result_count, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_plain_cases;
      send_fields(ACT_PLAIN, 100, 100, 200, 200, 10);   // new bucket
      send_fields(ACT_PLAIN, 100, 100, 200, 200, 10);   // identical
      send_fields(ACT_PLAIN, 120, 300, 180, 250, 10);   // contained in x
      send_fields(ACT_PLAIN, 50, 500, 300, 400, 10);    // contains entry
      send_fields(ACT_PLAIN, 1023, 1023, 0, 0, 255);
      send_fields(ACT_PLAIN, 0, 0, 1023, 1023, 0);
      send_fields(ACT_SPARE, 400, 0, 300, 1023, 0);     // action three
      for (int i = 0; i < 9; i++) send_fields(ACT_PLAIN, 900, 900 - i, 10, 10 + i, 77);
   endtask

   task automatic test_snap_merge;
      send_fields(ACT_SNAP, 10, 10, 20, 400, 12);       // vertical; bucket 10 is on the excluded lower edge, so no snap
      send_fields(ACT_SNAP, 5, 5, 600, 9, 9);           // horizontal
      send_fields(ACT_MERGE, 50, 0, 700, 5, 11);
      send_fields(ACT_MERGE, 0, 5, 9, 900, 11);
      send_fields(ACT_SNAP, 3, 3, 40, 40, 254);         // clamp at top
      send_fields(ACT_SNAP, 3, 7, 40, 41, 1);           // bucket zero neighbour
      send_fields(ACT_MERGE, 1, 2, 3, 4, 150);          // no neighbour
   endtask

   task automatic test_window_settings;
      write_window(0);
      send_fields(ACT_SNAP, 1, 2, 3, 4, 11);
      send_fields(ACT_MERGE, 5, 2, 3, 9, 12);
      write_window(63);
      send_fields(ACT_SNAP, 30, 2, 3, 900, 100);
      send_fields(ACT_MERGE, 1023, 0, 0, 1, 40);
   endtask

   function automatic seg_item_type random_segment(int lo, int hi);
      seg_item_type it;
      int r;
      r = $urandom_range(0, 9);
      it.action = r < 3 ? ACT_PLAIN : r < 6 ? ACT_SNAP : r < 9 ? ACT_MERGE : ACT_SPARE;
      it.sx = coord_type'($urandom); it.sy = coord_type'($urandom);
      it.ex = coord_type'($urandom); it.ey = coord_type'($urandom);
      it.bucket = BKT_W'($urandom_range(lo, hi));
      return it;
   endfunction

   task automatic test_random_phase(logic [WIN_W-1:0] w, int n, int lo, int hi);
      write_window(w);
      for (int i = 0; i < n; i++) send_segment(random_segment(lo, hi));
   endtask

   task automatic test_backpressure;
      hold_off = 1;
      // receiver hold-off counted in its own process while items keep coming
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
      join_none
      for (int i = 0; i < 6; i++) send_segment(random_segment(0, 255));
      drain_results();
      no_gaps = 1;
      for (int i = 0; i < 40; i++) send_segment(random_segment(60, 90));
      no_gaps = 0;
   endtask

   initial begin
      req.valid = 0; req.action = 0; req.start_x = 0; req.start_y = 0;
      req.end_x = 0; req.end_y = 0; req.bucket = 0;
      csr.valid = 0; csr.data = 0;
      hold_off = 0; no_gaps = 0;
      for (int b = 0; b < NUM_BUCKETS; b++) fill[b] = 0;
      occupied_now = 0;
      window_now = WINDOW_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_cases();
      test_snap_merge();
      test_window_settings();
      test_random_phase(4, 200, 0, 40);
      test_random_phase(1, 120, 200, 255);
      test_random_phase(17, 200, 0, 255);
      test_backpressure();
      test_random_phase(63, 150, 0, 255);
      test_random_phase(8, 80, 0, 255);
      drain_results();
      $display("%0d segments sent, %0d results checked, windows 0 to 63", item_count,
               result_count);
      $display("outcomes new %0d app %0d rej %0d rep %0d merge %0d drop %0d",
               outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
               outcome_seen[4], outcome_seen[5]);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
